// ===== sv/esa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_pkg: shared definitions for the encoder speed and acceleration estimator
// Widths, register indexes, command codes and the fixed-point saturation helper.
// ----------------------------------------------------------------------------
package esa_pkg;

	// Count width and fixed-point fraction bits
	localparam int COUNT_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH);

	// Configuration register widths
	localparam int PPR_W   = 16;
	localparam int DPP_W   = 9;
	localparam int GAIN_W  = 32;
	localparam int CFG_W   = 32;
	localparam int ANGLE_W = 26;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		CFG_PULSES_PER_REV    = 2'd0,
		CFG_DEGREES_PER_PULSE = 2'd1,
		CFG_SPEED_GAIN        = 2'd2,
		CFG_ACCEL_GAIN        = 2'd3
	} cfg_idx_t;

	// Command codes on the event channel
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Register reset values
	localparam logic [PPR_W-1:0]  PPR_RST  = PPR_W'(1000);
	localparam logic [DPP_W-1:0]  DPP_RST  = '0;
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(65536);

	// Sign-extend a count-width value to 32 bits
	function automatic logic signed [31:0] sext_cnt(input logic [COUNT_WIDTH-1:0] v);
		return 32'(signed'(v));
	endfunction

	// Shift a product magnitude right by FRAC_BITS, apply the sign, saturate to 32 bits.
	// ovf flags a magnitude already known to be far beyond range.
	function automatic logic signed [31:0] sat_scale(input logic neg, input logic ovf,
			input logic [63:0] prod);
		logic [63:0] q;
		q = prod >> FRAC_BITS;
		if (neg) begin
			if (ovf || q > 64'h0000_0000_8000_0000)
				return 32'sh8000_0000;
			return -signed'(q[31:0]);
		end
		if (ovf || q > 64'h0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		return signed'(q[31:0]);
	endfunction

endpackage

`default_nettype wire

// ===== sv/esa_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esa_ifs: valid/ready channels of the encoder speed and acceleration estimator
// Event channel (edge events and sample ticks) and result channel.
// ----------------------------------------------------------------------------
interface esa_evt_if;
	logic valid;
	logic ready;
	logic cmd;
	logic phase_a;
	logic phase_b;

	modport source (output valid, cmd, phase_a, phase_b, input ready);
	modport sink   (input valid, cmd, phase_a, phase_b, output ready);
endinterface

interface esa_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pulse_count;
	logic signed [31:0] delta_pulses;
	logic signed [31:0] speed_rpm;
	logic [30:0]        speed_magnitude;
	logic signed [31:0] acceleration;
	logic signed [31:0] revolutions;
	logic signed [25:0] angle_deg;

	modport source (output valid, pulse_count, delta_pulses, speed_rpm, speed_magnitude,
		acceleration, revolutions, angle_deg, input ready);
	modport sink   (input valid, pulse_count, delta_pulses, speed_rpm, speed_magnitude,
		acceleration, revolutions, angle_deg, output ready);
endinterface

`default_nettype wire

// ===== sv/encoder_speed_accel_estimator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_accel_estimator_unit: quadrature pulse counter with speed,
// acceleration, revolution and angle estimation
// Counts phase A edge events, estimates speed and acceleration on sample ticks
// and reports count, revolutions and angle for every event.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------------
//  evt     | in  | cmd, phase_a, phase_b
//  res     | out | pulse_count, delta_pulses, speed_rpm, speed_magnitude,
//          |     | acceleration, revolutions, angle_deg
//  cfg_*   | in  | write enable, register index, write data
//
//  Steps: after an event transfers, the restoring divider runs (one quotient bit a
//  cycle, COUNT_WIDTH steps). A sample tick then takes the speed product and its
//  saturation, then the acceleration product and its saturation; every event ends
//  with the angle product, each product through the shared 32x32 multiplier. The
//  next event can transfer in the cycle after the result is loaded.
//  evt.ready is high only while the sequencer is idle. A result waits in the output
//  register, so the next event is taken meanwhile; the sequencer stalls at its last
//  step only if the previous result has still not been taken.
//  Async reset clears all but datapath and result data; no clearing pass follows.
// ----------------------------------------------------------------------------
module encoder_speed_accel_estimator_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  esa_pkg::cfg_idx_t         cfg_idx,
	input  wire [esa_pkg::CFG_W-1:0]  cfg_wdata,
	esa_evt_if.sink                   evt,
	esa_res_if.source                 res
);
	import esa_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_DIV     = 9'b000000010,
		ST_SPD_MUL = 9'b000000100,
		ST_SPD_SAT = 9'b000001000,
		ST_ACC_MUL = 9'b000010000,
		ST_ACC_SAT = 9'b000100000,
		ST_ANG_MUL = 9'b001000000,
		ST_DONE    = 9'b010000000,
		ST_SPARE   = 9'b100000000
	} state_t;

	// Configuration registers
	logic [PPR_W-1:0]  ppr_q;
	logic [DPP_W-1:0]  dpp_q;
	logic [GAIN_W-1:0] speed_gain_q;
	logic [GAIN_W-1:0] accel_gain_q;

	// Estimator state
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] last_tick_q;
	logic signed [31:0]     delta_q;
	logic signed [31:0]     speed_q;
	logic signed [31:0]     spd_new_q;
	logic signed [31:0]     accel_q;

	// Sequencer and shared units
	state_t                 state_q;
	logic                   tick_q;
	logic                   cnt_neg_q;
	logic [COUNT_WIDTH-1:0] div_dvd_q;
	logic [COUNT_WIDTH-1:0] div_quo_q;
	logic [PPR_W-1:0]       div_rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [63:0]            prod_q;
	logic                   out_vld_q;

	logic                   evt_xfer;
	logic                   res_xfer;
	logic                   load_res;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [COUNT_WIDTH-1:0] cnt_mag;
	logic [PPR_W:0]         div_shl;
	logic [PPR_W+1:0]       div_trial;
	logic                   div_take;
	logic [31:0]            dmag;
	logic signed [32:0]     acc_diff;
	logic [32:0]            acc_mag;
	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            mul_p;
	logic signed [31:0]     revs;
	logic [31:0]            quo_ext;
	logic [ANGLE_W-1:0]     ang_raw;
	logic signed [ANGLE_W-1:0] angle;
	logic [30:0]            spd_mag;

	function automatic logic [31:0] dmag_of(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	assign evt_xfer  = evt.valid && evt.ready;
	assign res_xfer  = res.valid && res.ready;
	assign evt.ready = (state_q == ST_IDLE);
	assign load_res  = (state_q == ST_DONE) && (!out_vld_q || res.ready);

	// Count after an edge event
	always_comb begin
		count_next = count_q;
		if (evt.cmd == CMD_EDGE && evt.phase_a)
			count_next = evt.phase_b ? count_q + 1'b1 : count_q - 1'b1;
	end
	assign cnt_mag = count_next[COUNT_WIDTH-1] ? -count_next : count_next;

	// Restoring divider step
	assign div_shl   = {div_rem_q, div_dvd_q[COUNT_WIDTH-1]};
	assign div_trial = {1'b0, div_shl} - {2'b00, ppr_q};
	assign div_take  = !div_trial[PPR_W+1];

	// Operand magnitudes for the products
	assign dmag     = delta_q[31] ? 32'(-delta_q) : 32'(delta_q);
	assign acc_diff = 33'(spd_new_q) - 33'(speed_q);
	assign acc_mag  = acc_diff[32] ? 33'(-acc_diff) : 33'(acc_diff);

	// Shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SPD_MUL: begin
				mul_a = dmag;
				mul_b = speed_gain_q;
			end
			ST_ACC_MUL: begin
				mul_a = acc_mag[31:0];
				mul_b = accel_gain_q;
			end
			ST_ANG_MUL: begin
				mul_a = 32'(div_rem_q);
				mul_b = 32'(dpp_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The one multiplier
	assign mul_p = mul_a * mul_b;

	// Revolutions, angle and speed magnitude for the result
	assign quo_ext = 32'(div_quo_q);
	assign ang_raw = prod_q[ANGLE_W-1:0];
	always_comb begin
		if (ppr_q == '0) begin
			revs  = '0;
			angle = '0;
		end else begin
			revs  = cnt_neg_q ? -signed'(quo_ext) : signed'(quo_ext);
			angle = cnt_neg_q ? -signed'(ang_raw) : signed'(ang_raw);
		end
	end
	assign spd_mag = (speed_q == 32'sh8000_0000) ? 31'h7FFF_FFFF : 31'(dmag_of(speed_q));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q        <= PPR_RST;
			dpp_q        <= DPP_RST;
			speed_gain_q <= GAIN_RST;
			accel_gain_q <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PULSES_PER_REV:    ppr_q        <= cfg_wdata[PPR_W-1:0];
				CFG_DEGREES_PER_PULSE: dpp_q        <= cfg_wdata[DPP_W-1:0];
				CFG_SPEED_GAIN:        speed_gain_q <= cfg_wdata[GAIN_W-1:0];
				CFG_ACCEL_GAIN:        accel_gain_q <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, count state and shared units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= 1'b0;
			count_q     <= '0;
			last_tick_q <= '0;
			delta_q     <= '0;
			speed_q     <= '0;
			accel_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_xfer) begin
						tick_q    <= (evt.cmd == CMD_TICK);
						count_q   <= count_next;
						cnt_neg_q <= count_next[COUNT_WIDTH-1];
						div_dvd_q <= cnt_mag;
						div_quo_q <= '0;
						div_rem_q <= '0;
						div_cnt_q <= DIV_CNT_W'(COUNT_WIDTH - 1);
						if (evt.cmd == CMD_TICK) begin
							delta_q     <= sext_cnt(count_q - last_tick_q);
							last_tick_q <= count_q;
						end
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_rem_q <= div_take ? div_trial[PPR_W-1:0] : div_shl[PPR_W-1:0];
					div_quo_q <= {div_quo_q[COUNT_WIDTH-2:0], div_take};
					div_dvd_q <= {div_dvd_q[COUNT_WIDTH-2:0], 1'b0};
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0)
						state_q <= tick_q ? ST_SPD_MUL : ST_ANG_MUL;
				end
				ST_SPD_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_SPD_SAT;
				end
				ST_SPD_SAT: begin
					spd_new_q <= sat_scale(delta_q[31], 1'b0, prod_q);
					state_q   <= ST_ACC_MUL;
				end
				ST_ACC_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC_SAT;
				end
				ST_ACC_SAT: begin
					accel_q <= sat_scale(acc_diff[32], acc_mag[32] && (accel_gain_q != '0),
						prod_q);
					speed_q <= spd_new_q;
					state_q <= ST_ANG_MUL;
				end
				ST_ANG_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_res) begin
			out_vld_q <= 1'b1;
		end else if (res_xfer) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res.pulse_count     <= sext_cnt(count_q);
			res.delta_pulses    <= delta_q;
			res.speed_rpm       <= speed_q;
			res.speed_magnitude <= spd_mag;
			res.acceleration    <= accel_q;
			res.revolutions     <= revs;
			res.angle_deg       <= angle;
		end
	end

	assign res.valid = out_vld_q;

`ifndef SYNTHESIS
	// No second event is taken in the cycle after a transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		evt_xfer |=> !evt.ready)
		else $error("event taken while sequencer busy");

	// The divider leaves its loop after the last quotient bit
	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '0) |=> (state_q != ST_DIV))
		else $error("divider overran its step count");

	// A tick samples the current count as the new reference
	a_tick_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_xfer && evt.cmd == CMD_TICK) |=> (last_tick_q == count_q))
		else $error("tick reference count mismatch");
`endif

endmodule

`default_nettype wire
